// ----- rtl/wusa_pkg.sv -----
// Package for the worker update sum aggregator.
// Holds sizes, register indexes and result kind codes; no dependencies.
`timescale 1ns / 1ps
package wusa_pkg;
    localparam int SLOTS       = 512;
    localparam int MAX_UPDATES = 32;
    localparam int MAX_WORKERS = 16;
    localparam int SLOT_W      = 9;
    localparam int POS_W       = 5;
    localparam int WK_W        = 4;
    localparam int SUM_DEPTH   = MAX_UPDATES * SLOTS;
    localparam int SUM_AW      = POS_W + SLOT_W;

    localparam logic [5:0] REG_WORKER_COUNT = 6'd0;
    localparam logic [5:0] REG_UPDATE_COUNT = 6'd1;

    localparam logic       KIND_SUM  = 1'b0;
    localparam logic       KIND_DEST = 1'b1;

    // Request from the accumulator to the completion emitter.
    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        logic [31:0]       tag;
        logic [5:0]        nupd;
        logic [4:0]        nwk;
    } t_run;
endpackage

// ----- rtl/wusa_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
module wusa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 512
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ----- rtl/worker_update_sum_aggregator.sv -----
// Worker update sum aggregator. Each update item is a read of the sum and arrival memories,
// then add and write back. A last word also does a worker table lookup while the table is
// not full (one entry a cycle). A completing slot emits min(update_count, 32) sum items
// (one memory read each, sums cleared as read) and then one item per learned worker.
// After reset a clearing pass zeroes the sum and arrival memories, during which no item is
// accepted. Depends on wusa_pkg and wusa_ram.
`timescale 1ns / 1ps
module worker_update_sum_aggregator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [5:0]  i_cfg_index,
    input  logic [5:0]  i_cfg_data,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [8:0]  i_slot_index,
    input  logic [4:0]  i_position,
    input  logic signed [31:0] i_update_value,
    input  logic        i_last_word,
    input  logic [31:0] i_sender_ip,
    input  logic [47:0] i_sender_mac,
    input  logic [31:0] i_round_tag,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_result_kind,
    output logic [4:0]  o_out_position,
    output logic signed [31:0] o_sum_value,
    output logic [8:0]  o_out_slot,
    output logic [31:0] o_out_tag,
    output logic [31:0] o_dest_ip,
    output logic [47:0] o_dest_mac,
    output logic        o_last_result
);
    localparam int AW = wusa_pkg::SUM_AW;
    localparam int SW = wusa_pkg::SLOT_W;

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_ACC   = 3'd2;
    localparam logic [2:0] ST_LOOK  = 3'd3;
    localparam logic [2:0] ST_SUMS  = 3'd4;
    localparam logic [2:0] ST_DEST  = 3'd5;
    localparam logic [2:0] ST_SDRN  = 3'd6;

    logic [2:0]  r_state, n_state;
    logic [4:0]  r_wcount;
    logic [5:0]  r_ucount;
    logic [AW:0] r_clr;
    logic [4:0]  r_known;
    logic [31:0] r_wip  [wusa_pkg::MAX_WORKERS];
    logic [47:0] r_wmac [wusa_pkg::MAX_WORKERS];

    // Latched item.
    logic [SW-1:0] r_slot;
    logic [4:0]    r_pos;
    logic [31:0]   r_val, r_ip, r_tag;
    logic [47:0]   r_mac;
    logic          r_last;
    logic [5:0]    r_idx;
    logic          r_found;
    logic [4:0]    r_arr;
    wusa_pkg::t_run r_run;

    // Output register.
    logic        r_ov;
    logic        r_kind, r_olast;
    logic [4:0]  r_opos;
    logic [31:0] r_osum, r_oip;
    logic [47:0] r_omac;
    logic        r_pend;  // sum read in flight

    logic [5:0] idx_prev;
    assign idx_prev = r_idx - 6'd1;

    logic [4:0] nwk;
    logic [5:0] nupd;
    always_comb begin
        nwk = (r_wcount == 5'd0) ? 5'd1 : (r_wcount > 5'd16) ? 5'd16 : r_wcount;
        nupd = (r_ucount > 6'd32) ? 6'd32 : r_ucount;
    end

    // Memories.
    logic          s_we, a_we;
    logic [AW-1:0] s_wa, s_ra;
    logic [31:0]   s_wd, s_rd;
    logic [SW-1:0] a_wa, a_ra;
    logic [4:0]    a_wd, a_rd;

    wusa_ram #(.WIDTH(32), .DEPTH(wusa_pkg::SUM_DEPTH)) u_sums (
        .i_clk(i_clk), .i_we(s_we), .i_waddr(s_wa), .i_wdata(s_wd),
        .i_raddr(s_ra), .o_rdata(s_rd));
    wusa_ram #(.WIDTH(5), .DEPTH(wusa_pkg::SLOTS)) u_arr (
        .i_clk(i_clk), .i_we(a_we), .i_waddr(a_wa), .i_wdata(a_wd),
        .i_raddr(a_ra), .o_rdata(a_rd));

    logic acc_in;
    logic out_free;
    assign acc_in   = i_valid && !o_stall;
    assign o_stall  = (r_state != ST_IDLE);
    assign out_free = !r_ov || !i_stall;

    logic sum_rd;   // issue a sum read for emission this cycle
    always_comb begin
        sum_rd = (r_state == ST_SUMS) && (r_idx < r_run.nupd)
                 && (!r_pend || out_free);
    end

    logic load_out;  // a result moves into the output register this cycle
    always_comb begin
        load_out = (((r_state == ST_SUMS) || (r_state == ST_SDRN)) && r_pend && out_free)
                   || ((r_state == ST_DEST) && out_free && (r_idx < {1'b0, r_known}));
    end

    always_comb begin
        s_ra = {i_position, i_slot_index};
        a_ra = i_slot_index;
        s_we = 1'b0; s_wa = {r_pos, r_slot}; s_wd = s_rd + r_val;
        a_we = 1'b0; a_wa = r_slot; a_wd = 5'd0;
        case (r_state)
            ST_CLEAR: begin
                s_we = 1'b1; s_wa = r_clr[AW-1:0]; s_wd = 32'd0;
                a_we = 1'b1; a_wa = r_clr[SW-1:0];
            end
            ST_ACC: begin
                s_we = ({1'b0, r_pos} < nupd);
                if (r_last && !({1'b0, r_known} < {1'b0, nwk})) begin
                    a_we = 1'b1;
                    a_wd = ((a_rd + 5'd1) < nwk) ? a_rd + 5'd1 : 5'd0;
                end
            end
            ST_LOOK: begin
                if ((r_idx == {1'b0, r_known}) || r_found || r_idx[4]) begin
                    a_we = 1'b1;
                    a_wd = ((r_arr + 5'd1) < nwk) ? r_arr + 5'd1 : 5'd0;
                end
            end
            ST_SUMS, ST_SDRN: begin
                // A held sum is read again until it leaves, and cleared as it leaves.
                s_ra = (r_pend && !out_free) ? {idx_prev[4:0], r_run.slot}
                                             : {r_idx[4:0], r_run.slot};
                s_we = r_pend && out_free; s_wa = {idx_prev[4:0], r_run.slot};
                s_wd = 32'd0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_CLEAR;
            r_wcount <= 5'd2;
            r_ucount <= 6'd32;
            r_clr    <= '0;
            r_known  <= 5'd0;
            r_ov     <= 1'b0;
            r_pend   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we && i_cfg_index == wusa_pkg::REG_WORKER_COUNT) begin
                r_wcount <= i_cfg_data[4:0];
            end
            if (i_cfg_we && i_cfg_index == wusa_pkg::REG_UPDATE_COUNT) begin
                r_ucount <= i_cfg_data;
            end
            if (r_state == ST_CLEAR) begin
                r_clr <= r_clr + 1'b1;
            end
            if (load_out) begin
                r_ov <= 1'b1;
            end else if (out_free) begin
                r_ov <= 1'b0;
            end
            case (r_state)
                ST_LOOK: begin
                    if (((r_idx == {1'b0, r_known}) || r_idx[4]) && !r_found) begin
                        r_wip[r_known[3:0]]  <= r_ip;
                        r_wmac[r_known[3:0]] <= r_mac;
                        r_known <= r_known + 5'd1;
                    end
                end
                ST_SUMS, ST_SDRN: begin
                    if (sum_rd) begin
                        r_pend <= 1'b1;
                    end else if (r_pend && out_free) begin
                        r_pend <= 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

    // Payload and counters.
    always_ff @(posedge i_clk) begin
        if (acc_in) begin
            r_slot <= i_slot_index; r_pos <= i_position; r_val <= i_update_value;
            r_last <= i_last_word; r_ip <= i_sender_ip; r_mac <= i_sender_mac;
            r_tag  <= i_round_tag;
        end
        case (r_state)
            ST_ACC: begin
                r_idx <= 6'd0; r_found <= 1'b0; r_arr <= a_rd;
                r_run <= '{slot: r_slot, tag: r_tag, nupd: nupd, nwk: nwk};
            end
            ST_LOOK: begin
                if (n_state != ST_LOOK) begin
                    r_idx <= 6'd0;
                end else begin
                    r_idx <= r_idx + 6'd1;
                end
                if (r_idx < {1'b0, r_known} && !r_idx[4] && r_wip[r_idx[3:0]] == r_ip) begin
                    r_found <= 1'b1;
                end
            end
            ST_SUMS, ST_SDRN: begin
                if (r_pend && out_free) begin
                    r_kind <= wusa_pkg::KIND_SUM; r_opos <= idx_prev[4:0];
                    r_osum <= s_rd; r_oip <= '0; r_omac <= '0;
                    r_olast <= (r_idx >= r_run.nupd) && (r_known == 5'd0);
                end
                if (r_state == ST_SDRN && n_state != ST_SDRN) begin
                    r_idx <= 6'd0;
                end else if (sum_rd) begin
                    r_idx <= r_idx + 6'd1;
                end
            end
            ST_DEST: begin
                if (out_free && r_idx < {1'b0, r_known}) begin
                    r_kind <= wusa_pkg::KIND_DEST; r_opos <= r_idx[4:0];
                    r_osum <= '0; r_oip <= r_wip[r_idx[3:0]];
                    r_omac <= r_wmac[r_idx[3:0]];
                    r_olast <= (r_idx + 6'd1 == {1'b0, r_known});
                    r_idx <= r_idx + 6'd1;
                end
            end
            default: ;
        endcase
    end

    logic slot_done;  // completion decided in the accumulate or lookup step
    always_comb begin
        n_state   = r_state;
        slot_done = 1'b0;
        case (r_state)
            ST_CLEAR: if (r_clr == (AW+1)'(wusa_pkg::SUM_DEPTH - 1)) n_state = ST_IDLE;
            ST_IDLE:  if (acc_in) n_state = ST_ACC;
            ST_ACC: begin
                if (!r_last) begin
                    n_state = ST_IDLE;
                end else if ({1'b0, r_known} < {1'b0, nwk}) begin
                    n_state = ST_LOOK;
                end else begin
                    slot_done = !((a_rd + 5'd1) < nwk);
                    n_state   = slot_done ? ST_SUMS : ST_IDLE;
                end
            end
            ST_LOOK: begin
                if ((r_idx == {1'b0, r_known}) || r_found || r_idx[4]) begin
                    slot_done = !((r_arr + 5'd1) < nwk);
                    n_state   = slot_done ? ST_SUMS : ST_IDLE;
                end
            end
            ST_SUMS: if (r_idx >= r_run.nupd && !sum_rd) n_state = ST_SDRN;
            ST_SDRN: if (!r_pend) n_state = ST_DEST;
            ST_DEST: if (r_idx >= {1'b0, r_known} && out_free) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    assign o_valid        = r_ov;
    assign o_result_kind  = r_kind;
    assign o_out_position = r_opos;
    assign o_sum_value    = r_osum;
    assign o_out_slot     = r_run.slot;
    assign o_out_tag      = r_run.tag;
    assign o_dest_ip      = r_oip;
    assign o_dest_mac     = r_omac;
    assign o_last_result  = r_olast;

    // No item is taken while the memories are being cleared.
    a_noclr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_CLEAR |-> !acc_in) else $error("item taken during clear");
    // The worker table never grows past its depth.
    a_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_known <= 5'd16) else $error("worker table overflow");
    // A held result stays put while stalled.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov && i_stall |=> r_ov && $stable(r_osum) && $stable(r_opos))
        else $error("result changed under stall");
endmodule

// ----- tb/tb.sv -----
// Testbench for worker_update_sum_aggregator: a directed table, then random packets.
// Every result is checked against a predictor kept in this file. Depends on wusa_pkg and the aggregator.
`timescale 1ns / 1ps
module tb;
    localparam int LIMIT = 3_000_000;
    localparam int SETTLE = 80;

    typedef struct packed {
        logic [8:0]  slot;
        logic [4:0]  pos;
        logic [31:0] val;
        logic        last;
        logic [31:0] ip;
        logic [47:0] mac;
        logic [31:0] tag;
    } t_word;

    typedef struct packed {
        logic        kind;
        logic [4:0]  pos;
        logic [31:0] sum;
        logic [8:0]  slot;
        logic [31:0] tag;
        logic [31:0] ip;
        logic [47:0] mac;
        logic        last;
    } t_res;

    // Directed row: optional register writes before the item, optional typed first sum.
    typedef struct packed {
        logic        cfg;
        logic [5:0]  wk;
        logic [5:0]  upd;
        t_word       w;
        logic        typed;
        logic [31:0] first_sum;
    } t_row;

    logic        i_clk, i_rst_n;
    logic        i_cfg_we;
    logic [5:0]  i_cfg_index, i_cfg_data;
    logic        i_valid, o_stall;
    logic [8:0]  i_slot_index;
    logic [4:0]  i_position;
    logic signed [31:0] i_update_value;
    logic        i_last_word;
    logic [31:0] i_sender_ip;
    logic [47:0] i_sender_mac;
    logic [31:0] i_round_tag;
    logic        o_valid, i_stall;
    logic        o_result_kind;
    logic [4:0]  o_out_position;
    logic signed [31:0] o_sum_value;
    logic [8:0]  o_out_slot;
    logic [31:0] o_out_tag, o_dest_ip;
    logic [47:0] o_dest_mac;
    logic        o_last_result;

    worker_update_sum_aggregator uut (.*);

    // Predictor state.
    logic [31:0] sum_store [0:wusa_pkg::SUM_DEPTH-1];
    logic [4:0]  arrival_cnt [0:wusa_pkg::SLOTS-1];
    logic [31:0] table_ip [0:wusa_pkg::MAX_WORKERS-1];
    logic [47:0] table_mac [0:wusa_pkg::MAX_WORKERS-1];
    int          learned;
    logic [4:0]  reg_workers;
    logic [5:0]  reg_updates;

    t_res        pending_results[$];
    int          mismatches = 0;
    longint      cycles = 0;
    logic [31:0] ip_pool [0:19];

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // Receiver stalls: quiet stretches, short gaps and the odd long one.
    int stall_left = 0;
    int quiet_left = 0;
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_stall <= 1'b1;
        end else if (quiet_left > 0) begin
            quiet_left <= quiet_left - 1;
            i_stall <= 1'b0;
        end else if ($urandom_range(0, 9) == 0) begin
            quiet_left <= $urandom_range(20, 200);
            i_stall <= 1'b0;
        end else if ($urandom_range(0, 3) == 0) begin
            stall_left <= ($urandom_range(0, 15) == 0) ? $urandom_range(10, 40)
                                                       : $urandom_range(0, 2);
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        t_res got, want;
        if (i_rst_n && o_valid && !i_stall) begin
            got = '{o_result_kind, o_out_position, o_sum_value, o_out_slot, o_out_tag,
                    o_dest_ip, o_dest_mac, o_last_result};
            if (pending_results.size() == 0) begin
                mismatches = mismatches + 1;
                if (mismatches <= 10)
                    $display("unexpected result %p", got);
            end else begin
                want = pending_results.pop_front();
                if (got !== want) begin
                    mismatches = mismatches + 1;
                    if (mismatches <= 10)
                        $display("mismatch: expected %p, got %p", want, got);
                end
            end
        end
    end

    function automatic int used_workers();
        if (reg_workers == 0) return 1;
        if (reg_workers > wusa_pkg::MAX_WORKERS) return wusa_pkg::MAX_WORKERS;
        return reg_workers;
    endfunction

    function automatic int used_updates();
        int u;
        u = reg_updates;
        if (u > wusa_pkg::MAX_UPDATES) u = wusa_pkg::MAX_UPDATES;
        if (u > 32) u = 32;
        return u;
    endfunction

    // Folds one accepted word into the sums and queues any completion run it causes.
    task automatic absorb_update(input t_word w);
        int    nupd, nwk, first;
        bit    seen;
        t_res  r;
        nupd = used_updates();
        nwk = used_workers();
        seen = 0;
        if (w.pos < nupd)
            sum_store[{w.pos, w.slot}] = sum_store[{w.pos, w.slot}] + w.val;
        if (!w.last) return;
        if (learned < nwk) begin
            for (int i = 0; i < learned; i++)
                if (table_ip[i] == w.ip) seen = 1;
            if (!seen) begin
                table_ip[learned] = w.ip;
                table_mac[learned] = w.mac;
                learned++;
            end
        end
        if (arrival_cnt[w.slot] + 1 < nwk) begin
            arrival_cnt[w.slot] = arrival_cnt[w.slot] + 5'd1;
            return;
        end
        arrival_cnt[w.slot] = '0;
        first = pending_results.size();
        for (int i = 0; i < nupd; i++) begin
            r = '{wusa_pkg::KIND_SUM, i[4:0], sum_store[{i[4:0], w.slot}], w.slot, w.tag,
                  32'd0, 48'd0, 1'b0};
            sum_store[{i[4:0], w.slot}] = '0;
            pending_results.push_back(r);
        end
        for (int i = 0; i < learned; i++) begin
            r = '{wusa_pkg::KIND_DEST, i[4:0], 32'd0, w.slot, w.tag, table_ip[i],
                  table_mac[i], 1'b0};
            pending_results.push_back(r);
        end
        if (pending_results.size() > first)
            pending_results[pending_results.size() - 1].last = 1'b1;
    endtask

    task automatic write_reg(input logic [5:0] idx, input logic [5:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == wusa_pkg::REG_WORKER_COUNT) reg_workers = data[4:0];
        else if (idx == wusa_pkg::REG_UPDATE_COUNT) reg_updates = data;
    endtask

    // Registers change only once every expected result is out and the block has settled.
    task automatic reconfigure(input logic [5:0] wk, input logic [5:0] upd);
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        write_reg(wusa_pkg::REG_WORKER_COUNT, wk);
        write_reg(wusa_pkg::REG_UPDATE_COUNT, upd);
    endtask

    task automatic send_word(input t_word w);
        int gap;
        i_valid <= 1'b1;
        i_slot_index <= w.slot;
        i_position <= w.pos;
        i_update_value <= w.val;
        i_last_word <= w.last;
        i_sender_ip <= w.ip;
        i_sender_mac <= w.mac;
        i_round_tag <= w.tag;
        do @(posedge i_clk); while (o_stall);
        absorb_update(w);
        gap = ($urandom_range(0, 2) != 0) ? 0 :
              ($urandom_range(0, 10) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 3);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 7))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'hFFFF_FFFF;
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [5:0] pick_workers();
        case ($urandom_range(0, 5))
            0: return 6'd0;
            1: return 6'd16;
            2: return 6'd31;
            3: return 6'd1;
            default: return 6'($urandom_range(2, 5));
        endcase
    endfunction

    function automatic logic [5:0] pick_updates();
        case ($urandom_range(0, 6))
            0: return 6'd0;
            1: return 6'd32;
            2: return 6'd63;
            3: return 6'd1;
            default: return 6'($urandom_range(2, 8));
        endcase
    endfunction

    t_row rows [0:9];

    initial begin
        t_word w;
        int    sent, nwords, before_sz, idx;
        logic [8:0]  pkt_slot;
        logic [31:0] pkt_ip, pkt_tag;
        logic [47:0] pkt_mac;

        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        i_valid = 1'b0;
        i_stall = 1'b0;
        i_slot_index = '0;
        i_position = '0;
        i_update_value = '0;
        i_last_word = 1'b0;
        i_sender_ip = '0;
        i_sender_mac = '0;
        i_round_tag = '0;
        for (int i = 0; i < wusa_pkg::SUM_DEPTH; i++) sum_store[i] = '0;
        for (int i = 0; i < wusa_pkg::SLOTS; i++) arrival_cnt[i] = '0;
        learned = 0;
        reg_workers = 5'd2;
        reg_updates = 6'd32;
        for (int i = 0; i < 20; i++) ip_pool[i] = $urandom();
        ip_pool[0] = 32'h0000_0000;
        ip_pool[1] = 32'hFFFF_FFFF;

        // Two workers, two words: the first completion wraps in both directions.
        rows[0] = '{1'b1, 6'd2, 6'd2, '{9'd0, 5'd0, 32'h7FFF_FFFF, 1'b0, 32'h0,
                    48'h0, 32'h0}, 1'b0, 32'h0};
        rows[1] = '{1'b0, 6'd0, 6'd0, '{9'd0, 5'd1, 32'h8000_0000, 1'b1, 32'h0,
                    48'h0, 32'h0}, 1'b0, 32'h0};
        rows[2] = '{1'b0, 6'd0, 6'd0, '{9'd0, 5'd0, 32'h0000_0001, 1'b0, 32'hFFFF_FFFF,
                    48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF}, 1'b0, 32'h0};
        rows[3] = '{1'b0, 6'd0, 6'd0, '{9'd0, 5'd1, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF,
                    48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF}, 1'b1, 32'h8000_0000};
        // A position beyond the word count adds nothing but its last mark still counts.
        rows[4] = '{1'b0, 6'd0, 6'd0, '{9'd511, 5'd31, 32'h0000_0005, 1'b1, 32'h0,
                    48'h0, 32'h1}, 1'b0, 32'h0};
        rows[5] = '{1'b0, 6'd0, 6'd0, '{9'd511, 5'd0, 32'h0000_0007, 1'b1, 32'h0,
                    48'h0, 32'h2}, 1'b1, 32'h0000_0007};
        // A worker count of zero acts as one; no sum words, destinations only.
        rows[6] = '{1'b1, 6'd0, 6'd0, '{9'd3, 5'd0, 32'h0000_0009, 1'b1, 32'h0,
                    48'h0, 32'h3}, 1'b0, 32'h0};
        rows[7] = '{1'b0, 6'd0, 6'd0, '{9'd3, 5'd2, 32'h0000_0009, 1'b0, 32'h0,
                    48'h0, 32'h3}, 1'b0, 32'h0};
        // Saturating settings; a stale arrival count completes once the count is lowered.
        rows[8] = '{1'b1, 6'd31, 6'd63, '{9'd9, 5'd31, 32'h8000_0000, 1'b1,
                    32'h1234_5678, 48'h0123_4567_89AB, 32'h4}, 1'b0, 32'h0};
        rows[9] = '{1'b1, 6'd1, 6'd1, '{9'd9, 5'd0, 32'h7FFF_FFFF, 1'b1,
                    32'h1234_5678, 48'h0123_4567_89AB, 32'h5}, 1'b1, 32'h7FFF_FFFF};

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[r]) begin
            if (rows[r].cfg) reconfigure(rows[r].wk, rows[r].upd);
            before_sz = pending_results.size();
            send_word(rows[r].w);
            if (rows[r].typed && pending_results.size() > before_sz)
                pending_results[before_sz].sum = rows[r].first_sum;
        end

        // Random part: mostly whole packets into a few busy slots, some noise words.
        sent = 0;
        while (sent < 300) begin
            i_valid <= 1'b0;
            reconfigure(pick_workers(), pick_updates());
            for (int k = 0; k < 50 && sent < 300; ) begin
                pkt_slot = ($urandom_range(0, 3) == 0) ? 9'($urandom_range(0, 511))
                                                       : 9'($urandom_range(0, 3));
                idx = $urandom_range(0, 19);
                pkt_ip = ip_pool[idx];
                pkt_mac = {16'($urandom()), $urandom()};
                pkt_tag = $urandom();
                nwords = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 8)
                                                     : (used_updates() == 0 ? 1 : used_updates());
                for (int p = 0; p < nwords; p++) begin
                    w = '{pkt_slot, p[4:0], pick_value(), p == nwords - 1, pkt_ip,
                          pkt_mac, pkt_tag};
                    if ($urandom_range(0, 9) == 0) begin
                        w.pos = 5'($urandom());
                        w.last = 1'($urandom());
                    end
                    send_word(w);
                    sent++;
                    k++;
                end
            end
        end
        i_valid <= 1'b0;

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule
